[rtl/core/kdlp_pkg.sv]
// Package for the key debounce / long press core.
// Holds register indexes, reset values and the state, config and result types.
// No dependencies.
package kdlp_pkg;

    localparam int KeyW  = 8;
    localparam int IdxW  = 3;

    // Configuration register indexes
    localparam logic [IdxW-1:0] RegIdleCode  = 3'd0;
    localparam logic [IdxW-1:0] RegLongKeyA  = 3'd1;
    localparam logic [IdxW-1:0] RegLongTimeA = 3'd2;
    localparam logic [IdxW-1:0] RegLongKeyB  = 3'd3;
    localparam logic [IdxW-1:0] RegLongTimeB = 3'd4;

    // Configuration reset values
    localparam logic [KeyW-1:0] IdleCodeRst  = 8'd255;
    localparam logic [KeyW-1:0] LongKeyARst  = 8'd3;
    localparam logic [KeyW-1:0] LongTimeARst = 8'd200;
    localparam logic [KeyW-1:0] LongKeyBRst  = 8'd2;
    localparam logic [KeyW-1:0] LongTimeBRst = 8'd220;

    // Debounce qualification count and saturated release count
    localparam logic [KeyW-1:0] PressQual  = 8'd2;
    localparam logic [1:0]      ReleaseSat = 2'd2;

    typedef struct packed {
        logic [KeyW-1:0] idle_code;
        logic [KeyW-1:0] long_key_a;
        logic [KeyW-1:0] long_time_a;
        logic [KeyW-1:0] long_key_b;
        logic [KeyW-1:0] long_time_b;
    } t_cfg;

    typedef struct packed {
        logic [KeyW-1:0] press_count;
        logic [1:0]      release_count;
        logic [KeyW-1:0] last_key;
        logic [KeyW-1:0] accepted_key;
        logic            press_taken;
        logic            long_taken;
    } t_state;

    typedef struct packed {
        logic            event_valid;
        logic [KeyW-1:0] event_key;
        logic            event_long;
    } t_result;

endpackage

[rtl/core/kdlp_step.sv]
// Per-sample debounce step: next state and event word for one key sample.
// Pure combinational; depends on kdlp_pkg.
module kdlp_step (
    input  kdlp_pkg::t_cfg           i_cfg,
    input  kdlp_pkg::t_state         i_state,
    input  logic [kdlp_pkg::KeyW-1:0] i_key,
    output kdlp_pkg::t_state         o_state,
    output kdlp_pkg::t_result        o_result
);
    import kdlp_pkg::*;

    logic [KeyW-1:0] press_inc;
    logic [1:0]      release_inc;
    logic            last_special;
    logic            hit_a;
    logic            hit_b;
    logic [KeyW-1:0] limit;

    assign press_inc    = i_state.press_count + 8'd1;
    assign release_inc  = i_state.release_count + 2'd1;
    assign hit_a        = (i_state.last_key == i_cfg.long_key_a);
    assign hit_b        = (i_state.last_key == i_cfg.long_key_b);
    assign last_special = hit_a || hit_b;
    // Key a wins when both special codes match
    assign limit        = hit_a ? i_cfg.long_time_a : i_cfg.long_time_b;

    always_comb begin
        o_state              = i_state;
        o_result.event_valid = 1'b0;
        o_result.event_long  = 1'b0;

        if (i_key == i_cfg.idle_code) begin
            // Idle sample: count release, fire deferred short event or clear
            o_state.press_count   = '0;
            o_state.release_count = release_inc;
            if (release_inc > ReleaseSat) begin
                o_state.release_count = ReleaseSat;
                if (last_special && !i_state.long_taken) begin
                    o_state.press_taken  = 1'b1;
                    o_state.accepted_key = i_state.last_key;
                    o_state.last_key     = i_cfg.idle_code;
                    o_result.event_valid = 1'b1;
                end else begin
                    o_state.last_key     = i_cfg.idle_code;
                    o_state.accepted_key = i_cfg.idle_code;
                    o_state.press_taken  = 1'b0;
                    o_state.long_taken   = 1'b0;
                end
            end
        end else begin
            // Key down: advance press count, qualify when stable
            o_state.release_count = '0;
            o_state.press_count   = press_inc;
            if (i_key != i_state.last_key) begin
                o_state.last_key = i_key;
            end else if (press_inc > PressQual && !i_state.press_taken) begin
                if (last_special) begin
                    if (press_inc > limit) begin
                        o_state.press_count  = limit;
                        o_state.press_taken  = 1'b1;
                        o_state.long_taken   = 1'b1;
                        o_state.accepted_key = i_state.last_key;
                        o_result.event_valid = 1'b1;
                        o_result.event_long  = 1'b1;
                    end
                end else begin
                    o_state.press_count  = PressQual;
                    o_state.press_taken  = 1'b1;
                    o_state.accepted_key = i_state.last_key;
                    o_result.event_valid = 1'b1;
                end
            end
        end

        o_result.event_key = o_result.event_valid ? o_state.accepted_key : i_cfg.idle_code;
    end

endmodule

[rtl/core/key_debounce_long_press_core.sv]
// Key debounce with long-press detection, top level.
// An accepted sample word passes the input register, then the result register,
// to give its event word. One sample word per cycle while the event channel does not stall.
// Reset (synchronous, active low) clears debounce state, both valid flags and
// loads the configuration registers with their default values.
module key_debounce_long_press_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration write port
    input  logic                        i_cfg_we,
    input  logic [kdlp_pkg::IdxW-1:0]   i_cfg_idx,
    input  logic [kdlp_pkg::KeyW-1:0]   i_cfg_data,
    // sample channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [kdlp_pkg::KeyW-1:0]   i_key_sample,
    // event channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_event_valid,
    output logic [kdlp_pkg::KeyW-1:0]   o_event_key,
    output logic                        o_event_long
);
    import kdlp_pkg::*;

    t_cfg            r_cfg;
    t_state          r_state;
    t_state          n_state;
    t_result         n_result;
    t_result         r_result;
    logic            r_in_valid;
    logic [KeyW-1:0] r_in_key;
    logic            r_out_valid;
    logic            advance;
    logic            in_take;

    // Move the held sample into the result register when it is free
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.idle_code   <= IdleCodeRst;
            r_cfg.long_key_a  <= LongKeyARst;
            r_cfg.long_time_a <= LongTimeARst;
            r_cfg.long_key_b  <= LongKeyBRst;
            r_cfg.long_time_b <= LongTimeBRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                RegIdleCode:  r_cfg.idle_code   <= i_cfg_data;
                RegLongKeyA:  r_cfg.long_key_a  <= i_cfg_data;
                RegLongTimeA: r_cfg.long_time_a <= i_cfg_data;
                RegLongKeyB:  r_cfg.long_key_b  <= i_cfg_data;
                RegLongTimeB: r_cfg.long_time_b <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Hold the incoming sample word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_key <= i_key_sample;
        end
    end

    kdlp_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_key    (r_in_key),
        .o_state  (n_state),
        .o_result (n_result)
    );

    // Commit debounce state as each sample passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_valid = r_result.event_valid;
    assign o_event_key   = r_result.event_key;
    assign o_event_long  = r_result.event_long;

`ifndef SYNTH
    // Release count saturates and never reaches three
    a_release_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.release_count != 2'd3)
        else $error("release count out of range");

    // A long event is always a valid event
    a_long_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_long |-> o_event_valid)
        else $error("long flag without event");

    // Input stalls only when both stages are full and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled with room free");

    // An advanced sample leaves a result waiting
    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("advanced sample lost");
`endif

endmodule

[test/tb_key_debounce_long_press_core.sv]
// Self-checking bench for key_debounce_long_press_core: drives scan sample words
// under random idling on both channels and checks every event word against a
// debounce predictor kept in a small scoreboard class; depends on kdlp_pkg.
module tb_key_debounce_long_press_core;
    import kdlp_pkg::*;

    // Debounce predictor plus the queue of event words still to arrive
    class key_event_board;
        t_cfg    cfg;
        t_state  st;
        t_result expected_events[$];
        int      mismatches;
        int      events_seen;

        function new();
            cfg.idle_code   = IdleCodeRst;
            cfg.long_key_a  = LongKeyARst;
            cfg.long_time_a = LongTimeARst;
            cfg.long_key_b  = LongKeyBRst;
            cfg.long_time_b = LongTimeBRst;
            st          = '0;
            mismatches  = 0;
            events_seen = 0;
        endfunction

        function void set_reg(logic [IdxW-1:0] idx, logic [KeyW-1:0] data);
            case (idx)
                RegIdleCode:  cfg.idle_code   = data;
                RegLongKeyA:  cfg.long_key_a  = data;
                RegLongTimeA: cfg.long_time_a = data;
                RegLongKeyB:  cfg.long_key_b  = data;
                RegLongTimeB: cfg.long_time_b = data;
                default: ;
            endcase
        endfunction

        // Advance the debounce state by one sample and return its event word
        function t_result debounce_step(logic [KeyW-1:0] key);
            t_result         res;
            logic [KeyW-1:0] limit;
            logic            special;
            res     = '0;
            limit   = '0;
            special = 1'b1;
            if (key == cfg.idle_code) begin
                st.press_count   = '0;
                st.release_count = st.release_count + 2'd1;
                if (st.release_count > ReleaseSat) begin
                    st.release_count = ReleaseSat;
                    // a special key not yet taken long gives its short event on release
                    if ((st.last_key == cfg.long_key_a || st.last_key == cfg.long_key_b)
                            && !st.long_taken) begin
                        st.press_taken  = 1'b1;
                        res.event_valid = 1'b1;
                        st.accepted_key = st.last_key;
                    end else begin
                        st.accepted_key = cfg.idle_code;
                        st.press_taken  = 1'b0;
                        st.long_taken   = 1'b0;
                    end
                    st.last_key = cfg.idle_code;
                end
            end else begin
                st.release_count = '0;
                st.press_count   = st.press_count + 8'd1;
                if (key != st.last_key) begin
                    st.last_key = key;
                end else if (st.press_count > PressQual && !st.press_taken) begin
                    // first special key wins when both match
                    if (st.last_key == cfg.long_key_a) begin
                        limit = cfg.long_time_a;
                    end else if (st.last_key == cfg.long_key_b) begin
                        limit = cfg.long_time_b;
                    end else begin
                        special = 1'b0;
                    end
                    if (special) begin
                        if (st.press_count > limit) begin
                            st.press_count  = limit;
                            st.press_taken  = 1'b1;
                            st.long_taken   = 1'b1;
                            res.event_valid = 1'b1;
                            res.event_long  = 1'b1;
                            st.accepted_key = st.last_key;
                        end
                    end else begin
                        st.press_count  = PressQual;
                        st.press_taken  = 1'b1;
                        res.event_valid = 1'b1;
                        st.accepted_key = st.last_key;
                    end
                end
            end
            res.event_key = res.event_valid ? st.accepted_key : cfg.idle_code;
            return res;
        endfunction

        function void note_sample(logic [KeyW-1:0] key);
            expected_events.push_back(debounce_step(key));
        endfunction

        task report(string what);
            mismatches++;
            $display("MISMATCH: %s", what);
        endtask

        task check_event(t_result got);
            t_result want;
            events_seen++;
            if (expected_events.size() == 0) begin
                report($sformatf("event word %0d arrived with nothing expected", events_seen));
            end else begin
                want = expected_events.pop_front();
                if (got.event_valid !== want.event_valid) begin
                    report($sformatf("event word %0d: event_valid %b, want %b",
                                     events_seen, got.event_valid, want.event_valid));
                end
                if (got.event_key !== want.event_key) begin
                    report($sformatf("event word %0d: event_key %h, want %h",
                                     events_seen, got.event_key, want.event_key));
                end
                if (got.event_long !== want.event_long) begin
                    report($sformatf("event word %0d: event_long %b, want %b",
                                     events_seen, got.event_long, want.event_long));
                end
            end
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n      = 1'b0;
    logic              i_cfg_we     = 1'b0;
    logic [IdxW-1:0]   i_cfg_idx    = '0;
    logic [KeyW-1:0]   i_cfg_data   = '0;
    logic              i_in_valid   = 1'b0;
    logic              o_in_stall;
    logic [KeyW-1:0]   i_key_sample = '0;
    logic              o_out_valid;
    logic              i_out_stall  = 1'b0;
    logic              o_event_valid;
    logic [KeyW-1:0]   o_event_key;
    logic              o_event_long;

    key_event_board board;
    t_result        event_word;
    int             samples_sent = 0;
    int             send_max     = 3;
    int             stall_max    = 3;
    int             stall_left   = 0;

    key_debounce_long_press_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_key_sample  (i_key_sample),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_event_valid (o_event_valid),
        .o_event_key   (o_event_key),
        .o_event_long  (o_event_long)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Take event words and hold stall for a random count after each one
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            event_word.event_valid = o_event_valid;
            event_word.event_key   = o_event_key;
            event_word.event_long  = o_event_long;
            board.check_event(event_word);
            stall_left = (stall_max == 0) ? 0 : $urandom_range(0, stall_max);
        end
        if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int pick_pace();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 3;
            default: return 15;
        endcase
    endfunction

    // Idle a random count, then offer one sample word until it is taken
    task automatic send_sample(input logic [KeyW-1:0] key);
        int gap;
        gap = (send_max == 0) ? 0 : $urandom_range(0, send_max);
        repeat (gap) begin
            i_in_valid   <= 1'b0;
            i_key_sample <= KeyW'($urandom);
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_key_sample <= key;
        do @(posedge i_clk); while (o_in_stall);
        board.note_sample(key);
        samples_sent++;
    endtask

    task automatic hold_key(input logic [KeyW-1:0] key, input int count);
        repeat (count) send_sample(key);
    endtask

    // Drop valid and wait for every expected event word, then let the design idle
    task automatic settle();
        int waited;
        waited = 0;
        i_in_valid <= 1'b0;
        while (board.expected_events.size() != 0 && waited < 5000) begin
            @(posedge i_clk);
            waited++;
        end
        if (board.expected_events.size() != 0) begin
            board.report($sformatf("%0d event words never arrived",
                                   board.expected_events.size()));
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [IdxW-1:0] idx, input logic [KeyW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        board.set_reg(idx, data);
    endtask

    task automatic write_config(input logic [KeyW-1:0] idle_key, key_a, time_a,
                                key_b, time_b);
        settle();
        write_reg(RegIdleCode, idle_key);
        write_reg(RegLongKeyA, key_a);
        write_reg(RegLongTimeA, time_a);
        write_reg(RegLongKeyB, key_b);
        write_reg(RegLongTimeB, time_b);
        i_cfg_we <= 1'b0;
    endtask

    // Mostly press / hold / release sequences, some noise between them
    task automatic run_random(input int budget);
        int              stop_at;
        int              hold;
        int              thresh;
        logic [KeyW-1:0] key;
        logic            special;
        stop_at = samples_sent + budget;
        while (samples_sent < stop_at) begin
            if ($urandom_range(0, 5) == 0) begin
                send_max  = pick_pace();
                stall_max = pick_pace();
            end
            if ($urandom_range(0, 9) < 7) begin
                special = 1'b1;
                case ($urandom_range(0, 3))
                    0: begin
                        key    = board.cfg.long_key_a;
                        thresh = board.cfg.long_time_a;
                    end
                    1: begin
                        key    = board.cfg.long_key_b;
                        thresh = board.cfg.long_time_b;
                    end
                    default: begin
                        key     = KeyW'($urandom);
                        thresh  = 0;
                        special = 1'b0;
                    end
                endcase
                // hold around the long threshold, short of it, or past it
                if (special) begin
                    case ($urandom_range(0, 3))
                        0:       hold = $urandom_range(1, 4);
                        1:       hold = $urandom_range(1, thresh + 1);
                        2:       hold = thresh + $urandom_range(0, 4);
                        default: hold = thresh + 2 + $urandom_range(0, 8);
                    endcase
                end else if ($urandom_range(0, 29) == 0) begin
                    // long enough that the press counter can wrap
                    hold = $urandom_range(250, 300);
                end else begin
                    hold = $urandom_range(1, 8);
                end
                hold_key(key, (hold < 1) ? 1 : hold);
                // switch keys without a release now and then
                if ($urandom_range(0, 4) == 0) begin
                    hold_key(KeyW'($urandom), $urandom_range(1, 6));
                end
                hold_key(board.cfg.idle_code, $urandom_range(0, 5));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 3) == 0) begin
                        send_sample(board.cfg.idle_code);
                    end else begin
                        send_sample(KeyW'($urandom));
                    end
                end
            end
        end
    endtask

    initial begin
        board = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: lowest code, brief special press, early release, key change
        hold_key(8'h00, 4);
        hold_key(IdleCodeRst, 3);
        hold_key(LongKeyARst, 1);
        hold_key(IdleCodeRst, 3);
        hold_key(LongKeyBRst, 4);
        hold_key(8'h7E, 2);
        hold_key(IdleCodeRst, 3);
        hold_key(8'hFE, 3);
        hold_key(IdleCodeRst, 2);

        // Default settings, long holds for the special keys
        run_random(250);
        // Extreme codes, shortest legal and longest legal threshold
        write_config(8'h00, 8'hFF, 8'd3, 8'h80, 8'd254);
        run_random(180);
        // Idle code equal to a special key
        write_config(8'h40, 8'h40, 8'd5, 8'h41, 8'd6);
        run_random(80);
        // Both special keys the same
        write_config(8'hFF, 8'h11, 8'd4, 8'h11, 8'd8);
        run_random(80);
        // Threshold never reached, and threshold below the qualify count
        write_config(8'h7F, 8'h22, 8'd255, 8'h23, 8'd1);
        run_random(150);
        write_config(8'h33, 8'hA5, 8'd0, 8'h5A, 8'd2);
        run_random(80);
        repeat (3) begin
            write_config(KeyW'($urandom), KeyW'($urandom), KeyW'($urandom_range(3, 20)),
                         KeyW'($urandom), KeyW'($urandom_range(3, 20)));
            run_random(60);
        end

        settle();
        if (board.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Hard stop in case a handshake hangs
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
